[rtl/core/jhs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_pkg: shared types and constants of the 5-point Jacobi heat stencil
// Field widths, register indexes and the queue word passed from the front
// end to the back end.
// ----------------------------------------------------------------------------
package jhs_pkg;

   // payload widths
   localparam int VAL_W     = 48;           // signed Q31.16 cell value
   localparam int PAIR_W    = VAL_W + 1;    // sum of two cells
   localparam int SUM_W     = VAL_W + 3;    // 4c + n + s + e + w
   localparam int ROW_W     = 12;
   localparam int COL_IDX_W = 10;

   // configuration registers
   localparam int GH_W       = 13;
   localparam int GW_W       = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b1;

   localparam logic [GH_W-1:0] GH_RESET = 13'd1024;
   localparam logic [GW_W-1:0] GW_RESET = 11'd1024;
   localparam logic [GH_W-1:0] H_MIN    = 13'd3;
   localparam logic [GH_W-1:0] H_MAX    = 13'd4096;
   localparam int              W_MIN    = 3;

   // one queued word: the operands of one emitting cell plus its position
   typedef struct packed {
      logic [VAL_W-1:0]     mid;       // cell (y-1,x)
      logic [VAL_W-1:0]     arrival;   // arriving cell (y,x)
      logic [PAIR_W-1:0]    ns;        // north + south
      logic [PAIR_W-1:0]    ew;        // east + west
      logic                 use_st;    // interior cell, apply the stencil
      logic                 last_row;  // arriving row is the final one
      logic [ROW_W-1:0]     row;       // row of the arriving cell
      logic [COL_IDX_W-1:0] col;
   } entry_type;

endpackage
`default_nettype wire

[rtl/core/jhs_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_queue: short queue between front and back end
// Register-based FIFO of stencil words; count is exported so the front end
// can throttle its input early enough for its own in-flight word.
// ----------------------------------------------------------------------------
module jhs_queue
   import jhs_pkg::*;
#(
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire entry_type        push_word,
   input  wire logic             pop,
   output entry_type             head_word,
   output logic                  empty,
   output logic [CNT_W-1:0]      count
);

   entry_type          words_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         words_ff[tail_ff] <= push_word;
      end
   end

   assign head_word = words_ff[head_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < CNT_W'(DEPTH)))
      else $error("jhs_queue: push into a full queue");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("jhs_queue: pop from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && pop) |=> (count_ff == $past(count_ff)))
      else $error("jhs_queue: count moved on simultaneous push and pop");

endmodule
`default_nettype wire

[rtl/core/jhs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_front: input side of the heat stencil
// Keeps the raster position and the config registers, classifies each cell,
// reads and updates the two line stores, and pushes one word per emitting
// cell into the queue with the neighbor pair sums already formed.
// ----------------------------------------------------------------------------
module jhs_front
   import jhs_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int QUEUE_DEPTH = 4,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // cell input
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [VAL_W-1:0]      req_cell_in,
   // config write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   // queue side
   output logic                       q_push,
   output entry_type                  q_word,
   input  wire logic [CNT_W-1:0]      q_count
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCAP_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (WCAP_W > GW_W) ? WCAP_W : GW_W;

   // config registers
   logic [GH_W-1:0]  grid_height_ff, grid_height_in;
   logic [GW_W-1:0]  grid_width_ff, grid_width_in;

   // raster position
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   // line stores and their registered read data
   logic [VAL_W-1:0] upper_store_ff  [MAX_WIDTH];
   logic [VAL_W-1:0] middle_store_ff [MAX_WIDTH];
   logic [VAL_W-1:0] rd_mid_ff, rd_east_ff, rd_north_ff;

   // word in flight between line store read and queue push
   logic             s1_valid_ff, s1_valid_in;
   logic [VAL_W-1:0] s1_cell_ff;
   logic             s1_emit_ff, s1_use_st_ff, s1_last_row_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [VAL_W-1:0] held_left_ff;

   logic             accept;
   logic [GH_W-1:0]  h_eff;
   logic [CMP_W-1:0] w_eff, gw_ext;
   logic             last_col, last_row;
   logic             emit, use_st;
   logic [COL_W-1:0] east_addr;

   assign csr_ready = 1'b1;

   // config decode
   always_comb begin
      grid_height_in = grid_height_ff;
      grid_width_in  = grid_width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_HEIGHT: grid_height_in = csr_data;
            CSR_GRID_WIDTH:  grid_width_in  = csr_data[GW_W-1:0];
            default: ;
         endcase
      end
   end

   // saturated frame size and cell classification
   always_comb begin
      if (grid_height_ff < H_MIN) begin
         h_eff = H_MIN;
      end else if (grid_height_ff > H_MAX) begin
         h_eff = H_MAX;
      end else begin
         h_eff = grid_height_ff;
      end
      gw_ext = CMP_W'(grid_width_ff);
      if (gw_ext < CMP_W'(W_MIN)) begin
         w_eff = CMP_W'(W_MIN);
      end else if (gw_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = gw_ext;
      end
      last_col  = CMP_W'(col_ff) >= (w_eff - CMP_W'(1));
      last_row  = {1'b0, row_ff} >= (h_eff - GH_W'(1));
      emit      = (row_ff != '0);
      use_st    = (row_ff >= ROW_W'(2)) && (col_ff != '0) && !last_col;
      east_addr = (col_ff == COL_W'(MAX_WIDTH - 1)) ? '0 : col_ff + COL_W'(1);
   end

   // position update
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // room for the arriving cell and the word already in flight
   assign req_full    = ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_valid_ff))
                        >= (CNT_W + 1)'(QUEUE_DEPTH);
   assign accept      = req_push && !req_full;
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_height_ff <= GH_RESET;
         grid_width_ff  <= GW_RESET;
         row_ff         <= '0;
         col_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         held_left_ff   <= '0;
      end else begin
         grid_height_ff <= grid_height_in;
         grid_width_ff  <= grid_width_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         s1_valid_ff    <= s1_valid_in;
         if (s1_valid_ff) begin
            held_left_ff <= rd_mid_ff;
         end
      end
   end

   // line stores: middle read twice and written on accept, upper written in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_mid_ff               <= middle_store_ff[col_ff];
         rd_east_ff              <= middle_store_ff[east_addr];
         rd_north_ff             <= upper_store_ff[col_ff];
         middle_store_ff[col_ff] <= req_cell_in;
      end
      if (s1_valid_ff) begin
         upper_store_ff[s1_col_ff] <= rd_mid_ff;
      end
   end

   // in-flight word payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff     <= req_cell_in;
         s1_emit_ff     <= emit;
         s1_use_st_ff   <= use_st;
         s1_last_row_ff <= last_row;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
      end
   end

   // pair sums and queue word; row 0 cells only update the stores
   always_comb begin
      q_push            = s1_valid_ff && s1_emit_ff;
      q_word.mid        = rd_mid_ff;
      q_word.arrival    = s1_cell_ff;
      q_word.ns         = {rd_north_ff[VAL_W-1], rd_north_ff}
                        + {s1_cell_ff[VAL_W-1], s1_cell_ff};
      q_word.ew         = {rd_east_ff[VAL_W-1], rd_east_ff}
                        + {held_left_ff[VAL_W-1], held_left_ff};
      q_word.use_st     = s1_use_st_ff;
      q_word.last_row   = s1_last_row_ff;
      q_word.row        = s1_row_ff;
      q_word.col        = COL_IDX_W'(s1_col_ff);
   end

endmodule
`default_nettype wire

[rtl/core/jhs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_back: result side of the heat stencil
// Finishes the stencil sum of the queue head, emits one result, or two on
// the final row, and holds it in the result register until popped.
// ----------------------------------------------------------------------------
module jhs_back
   import jhs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // queue side
   input  wire logic                  q_empty,
   input  wire entry_type             q_head,
   output logic                       q_pop,
   // result output
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [VAL_W-1:0]           rsp_cell_out,
   output logic [ROW_W-1:0]           rsp_row_index,
   output logic [COL_IDX_W-1:0]       rsp_col_index,
   output logic                       rsp_last_of_run
);

   logic                 out_valid_ff, out_valid_in;
   logic                 phase_ff, phase_in;    // second result of a final-row cell pending
   logic [VAL_W-1:0]     cell_ff, cell_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_IDX_W-1:0] col_ff, col_in;
   logic                 last_ff, last_in;

   logic                 out_free, load;
   logic [SUM_W-1:0]     sum;

   // 4c + (n+s) + (e+w), then floor divide by 8
   assign sum = {q_head.mid[VAL_W-1], q_head.mid, 2'b00}
              + {{2{q_head.ns[PAIR_W-1]}}, q_head.ns}
              + {{2{q_head.ew[PAIR_W-1]}}, q_head.ew};

   assign out_free = !out_valid_ff || rsp_pop;
   assign load     = out_free && !q_empty;

   // result select and queue advance
   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      cell_in      = cell_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         col_in       = q_head.col;
         if (!phase_ff) begin
            cell_in = q_head.use_st ? sum[SUM_W-1:3] : q_head.mid;
            row_in  = q_head.row - ROW_W'(1);
            last_in = !q_head.last_row;
            if (q_head.last_row) begin
               phase_in = 1'b1;
            end else begin
               q_pop = 1'b1;
            end
         end else begin
            // final row cell passes through
            cell_in  = q_head.arrival;
            row_in   = q_head.row;
            last_in  = 1'b1;
            phase_in = 1'b0;
            q_pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      last_ff <= last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_cell_out    = cell_ff;
   assign rsp_row_index   = row_ff;
   assign rsp_col_index   = col_ff;
   assign rsp_last_of_run = last_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !q_empty)
      else $error("jhs_back: second result pending without a queued word");
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> q_head.last_row)
      else $error("jhs_back: second result pending for a non-final row");
   assert property (@(posedge clock) disable iff (reset)
      $rose(phase_ff) |-> (out_valid_ff && !last_ff))
      else $error("jhs_back: first of two results marked as last");

endmodule
`default_nettype wire

[rtl/core/jacobi_heat_stencil_5pt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_heat_stencil_5pt: streaming 5-point Jacobi heat stencil
// Throughput: one cell per cycle while the queue has room; on the final row
// each cell yields two results and the single result register throttles input.
// The line store read-modify-write takes one cell per cycle.
// Reset: synchronous; counters, queue and result register clear at once,
// both config registers return to 1024, line stores are not cleared.
// ----------------------------------------------------------------------------
module jacobi_heat_stencil_5pt
   import jhs_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // cell input
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [VAL_W-1:0]      req_cell_in,
   // result output
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [VAL_W-1:0]           rsp_cell_out,
   output logic [ROW_W-1:0]           rsp_row_index,
   output logic [COL_IDX_W-1:0]       rsp_col_index,
   output logic                       rsp_last_of_run,
   // config write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic             q_push, q_pop, q_empty;
   entry_type        q_word, q_head;
   logic [CNT_W-1:0] q_count;

   // classify cells and access line stores
   jhs_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_cell_in (req_cell_in),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_push      (q_push),
      .q_word      (q_word),
      .q_count     (q_count)
   );

   // decoupling queue
   jhs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .pop       (q_pop),
      .head_word (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   // stencil finish and result delivery
   jhs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cell_out    (rsp_cell_out),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire
